[hdl/mrd_pkg.sv]
// Shared types and constants for the memory region decoder.
// No dependencies; imported by mrd_cell and memory_region_decoder_top.
package mrd_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned AddrBitsDef   = 32;
  localparam int unsigned TagW          = 4;
  localparam int unsigned StatusW       = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_NO_REGION  = 3'd2,
    ST_OVERLAP    = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Control part of the token that walks down the cell row.
  // For a registration, done marks that the insert point has been found.
  typedef struct packed {
    logic            valid;
    logic            kind;
    logic            is_write;
    logic            misalign;
    logic            done;
    logic            hit;
    logic            have_prev;
    logic            have_next;
    logic [TagW-1:0] tag;
  } ctl_t;

endpackage

[hdl/mrd_cell.sv]
// One slot of the region table plus one stage of the lookup token.
// Depends on mrd_pkg; chained by memory_region_decoder_top.
module mrd_cell #(
  parameter int unsigned AddrBits = mrd_pkg::AddrBitsDef,
  parameter int unsigned CntW     = $clog2(mrd_pkg::MaxRegionsDef + 1),
  parameter int unsigned Idx      = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // token from the left neighbor
  input  mrd_pkg::ctl_t            ctl_i,
  input  logic [AddrBits-1:0]      key_i,
  input  logic [AddrBits:0]        span_i,
  input  logic [AddrBits:0]        prev_i,
  input  logic [AddrBits-1:0]      next_i,
  // token to the right neighbor
  output mrd_pkg::ctl_t            ctl_o,
  output logic [AddrBits-1:0]      key_o,
  output logic [AddrBits:0]        span_o,
  output logic [AddrBits:0]        prev_o,
  output logic [AddrBits-1:0]      next_o,
  // table occupancy and insert broadcast
  input  logic [CntW-1:0]          count_i,
  input  logic                     commit_i,
  input  logic [AddrBits-1:0]      ins_begin_i,
  input  logic [AddrBits:0]        ins_limit_i,
  input  logic [mrd_pkg::TagW-1:0] ins_label_i,
  // entry of the left neighbor, for the shift on insert
  input  logic                     left_g_i,
  input  logic [AddrBits-1:0]      left_begin_i,
  input  logic [AddrBits:0]        left_limit_i,
  input  logic [mrd_pkg::TagW-1:0] left_label_i,
  output logic                     g_o,
  output logic [AddrBits-1:0]      begin_o,
  output logic [AddrBits:0]        limit_o,
  output logic [mrd_pkg::TagW-1:0] label_o
);
  import mrd_pkg::*;

  logic [AddrBits-1:0] begin_q;
  logic [AddrBits:0]   limit_q;
  logic [TagW-1:0]     label_q;
  logic                slot_used;

  ctl_t                ctl_d, ctl_q;
  logic [AddrBits-1:0] key_q, next_d, next_q;
  logic [AddrBits:0]   span_q, prev_d, prev_q;

  assign slot_used = CntW'(Idx) < count_i;

  always_comb begin
    ctl_d  = ctl_i;
    prev_d = prev_i;
    next_d = next_i;
    if (ctl_i.valid && slot_used && !ctl_i.done) begin
      if (!ctl_i.kind) begin
        if (begin_q <= key_i && limit_q >= span_i) begin
          ctl_d.done = 1'b1;
          ctl_d.hit  = 1'b1;
          ctl_d.tag  = label_q;
        end else if (begin_q > key_i) begin
          ctl_d.done = 1'b1;
        end
      end else begin
        if (begin_q <= key_i) begin
          ctl_d.have_prev = 1'b1;
          prev_d          = limit_q;
        end else begin
          ctl_d.done      = 1'b1;
          ctl_d.have_next = 1'b1;
          next_d          = begin_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_i;
    span_q <= span_i;
    prev_q <= prev_d;
    next_q <= next_d;
  end

  // g: this slot stays put on insert (used and starts at or before the new start)
  assign g_o = slot_used && begin_q <= ins_begin_i;

  always_ff @(posedge clk_i) begin
    if (commit_i && !g_o) begin
      if (left_g_i) begin
        begin_q <= ins_begin_i;
        limit_q <= ins_limit_i;
        label_q <= ins_label_i;
      end else begin
        begin_q <= left_begin_i;
        limit_q <= left_limit_i;
        label_q <= left_label_i;
      end
    end
  end

  assign ctl_o   = ctl_q;
  assign key_o   = key_q;
  assign span_o  = span_q;
  assign prev_o  = prev_q;
  assign next_o  = next_q;
  assign begin_o = begin_q;
  assign limit_o = limit_q;
  assign label_o = label_q;

endmodule

[hdl/memory_region_decoder_top.sv]
// Memory region decoder: sorted region table held in a row of mrd_cell slots.
// Depends on mrd_pkg and mrd_cell.
//
// Each command (access lookup or region registration) is taken when start_i
// is high and busy_o is low. The command walks the row of MAX_REGIONS cells,
// one cell per cycle; its result appears on the result ports with done_o high
// for one cycle once the token has passed the head register and every cell,
// and a new command can be taken while done_o is high, not before.
// The receiver cannot stall;
// done_o marks the only cycle in which a result beat is shown. A successful
// registration shifts the table in the same cycle the result is latched.
module memory_region_decoder_top #(
  parameter int unsigned MAX_REGIONS = mrd_pkg::MaxRegionsDef,
  parameter int unsigned ADDR_BITS   = mrd_pkg::AddrBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [ADDR_BITS-1:0]        address_i,
  input  logic [1:0]                  size_log_i,
  input  logic                        is_write_i,
  input  logic [ADDR_BITS-1:0]        new_start_i,
  input  logic [ADDR_BITS:0]          new_end_i,
  input  logic [mrd_pkg::TagW-1:0]    new_tag_i,
  output logic                        done_o,
  output logic [mrd_pkg::StatusW-1:0] status_o,
  output logic [mrd_pkg::TagW-1:0]    hit_tag_o,
  output logic                        fault_write_o
);
  import mrd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);

  logic                accept;
  logic                busy_q;
  logic [CntW-1:0]     count_q;

  ctl_t                hctl_d, hctl_q;
  logic [ADDR_BITS-1:0] hkey_d, hkey_q;
  logic [ADDR_BITS:0]   hspan_d, hspan_q;
  logic                 misalign;

  // token chain, index 0 is the head register
  ctl_t                 ctl_w  [MAX_REGIONS+1];
  logic [ADDR_BITS-1:0] key_w  [MAX_REGIONS+1];
  logic [ADDR_BITS:0]   span_w [MAX_REGIONS+1];
  logic [ADDR_BITS:0]   prev_w [MAX_REGIONS+1];
  logic [ADDR_BITS-1:0] next_w [MAX_REGIONS+1];

  // table entries, for the neighbor shift
  logic                 g_w     [MAX_REGIONS];
  logic [ADDR_BITS-1:0] begin_w [MAX_REGIONS];
  logic [ADDR_BITS:0]   limit_w [MAX_REGIONS];
  logic [TagW-1:0]      label_w [MAX_REGIONS];

  ctl_t                 fctl;
  logic                 overlap, full, commit, last;
  status_e              status_d, status_q;
  logic [TagW-1:0]      tag_d, tag_q;
  logic                 fw_d, fw_q, done_q;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_comb begin
    case (size_log_i)
      SZ_BYTE: misalign = 1'b0;
      SZ_HALF: misalign = address_i[0];
      SZ_WORD: misalign = |address_i[1:0];
      default: misalign = 1'b1;
    endcase
  end

  always_comb begin
    hctl_d          = '0;
    hctl_d.valid    = accept;
    hctl_d.kind     = kind_i;
    if (kind_i) begin
      hctl_d.tag = new_tag_i;
      hkey_d     = new_start_i;
      hspan_d    = new_end_i;
    end else begin
      hctl_d.is_write = is_write_i;
      hctl_d.misalign = misalign;
      hctl_d.done     = misalign;
      hkey_d          = address_i;
      hspan_d         = {1'b0, address_i} + ((ADDR_BITS+1)'(1) << size_log_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hctl_q <= '0;
    end else begin
      hctl_q <= hctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hkey_q  <= hkey_d;
    hspan_q <= hspan_d;
  end

  assign ctl_w[0]  = hctl_q;
  assign key_w[0]  = hkey_q;
  assign span_w[0] = hspan_q;
  assign prev_w[0] = '0;
  assign next_w[0] = '0;

  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
    logic                 lg;
    logic [ADDR_BITS-1:0] lb;
    logic [ADDR_BITS:0]   ll;
    logic [TagW-1:0]      lt;

    if (k == 0) begin : g_first
      // leftmost slot always takes the new region when it moves
      assign lg = 1'b1;
      assign lb = '0;
      assign ll = '0;
      assign lt = '0;
    end else begin : g_rest
      assign lg = g_w[k-1];
      assign lb = begin_w[k-1];
      assign ll = limit_w[k-1];
      assign lt = label_w[k-1];
    end

    mrd_cell #(
      .AddrBits(ADDR_BITS),
      .CntW    (CntW),
      .Idx     (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_w[k]),
      .key_i       (key_w[k]),
      .span_i      (span_w[k]),
      .prev_i      (prev_w[k]),
      .next_i      (next_w[k]),
      .ctl_o       (ctl_w[k+1]),
      .key_o       (key_w[k+1]),
      .span_o      (span_w[k+1]),
      .prev_o      (prev_w[k+1]),
      .next_o      (next_w[k+1]),
      .count_i     (count_q),
      .commit_i    (commit),
      .ins_begin_i (key_w[MAX_REGIONS]),
      .ins_limit_i (span_w[MAX_REGIONS]),
      .ins_label_i (ctl_w[MAX_REGIONS].tag),
      .left_g_i    (lg),
      .left_begin_i(lb),
      .left_limit_i(ll),
      .left_label_i(lt),
      .g_o         (g_w[k]),
      .begin_o     (begin_w[k]),
      .limit_o     (limit_w[k]),
      .label_o     (label_w[k])
    );
  end

  // token leaving the last cell carries the whole decision
  assign fctl    = ctl_w[MAX_REGIONS];
  assign last    = fctl.valid;
  assign overlap = (fctl.have_prev && prev_w[MAX_REGIONS] > {1'b0, key_w[MAX_REGIONS]}) ||
                   (fctl.have_next && {1'b0, next_w[MAX_REGIONS]} < span_w[MAX_REGIONS]);
  assign full    = count_q >= CntW'(MAX_REGIONS);
  assign commit  = last && fctl.kind && !overlap && !full;

  always_comb begin
    tag_d = '0;
    fw_d  = 1'b0;
    if (fctl.kind) begin
      if (overlap) begin
        status_d = ST_OVERLAP;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_OK;
      end
    end else begin
      fw_d = fctl.is_write;
      if (fctl.misalign) begin
        status_d = ST_MISALIGNED;
      end else if (fctl.hit) begin
        status_d = ST_OK;
        tag_d    = fctl.tag;
      end else begin
        status_d = ST_NO_REGION;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= last;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last) begin
        busy_q <= 1'b0;
      end
      if (commit) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      fw_q     <= fw_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign hit_tag_o     = tag_q;
  assign fault_write_o = fw_q;

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> count_q == $past(count_q) + CntW'(1))
    else $error("region count did not advance on insert");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_REGIONS))
    else $error("region count beyond table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after accepted command");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result beat while command still in flight");

  a_tag_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && hit_tag_o != '0 |-> status_o == ST_OK)
    else $error("nonzero tag on a failed result");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for memory_region_decoder_top: directed and random region registrations
// and access lookups, each result checked against a cycle-free table model.
// Depends on mrd_pkg and the RTL of memory_region_decoder_top.
module testbench;
  import mrd_pkg::*;

  localparam int unsigned Depth      = MaxRegionsDef;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandItems  = 1130;
  localparam logic [32:0] AddrTop    = 33'h1_0000_0000;
  localparam logic        KIND_ACCESS   = 1'b0;
  localparam logic        KIND_REGISTER = 1'b1;
  localparam logic [1:0]  SZ_UNDEF      = 2'd3;

  typedef struct {
    status_e        status;
    logic [TagW-1:0] tag;
    logic           wr;
  } outcome_t;

  typedef struct {
    logic            kind;
    logic [31:0]     addr;
    logic [1:0]      slog;
    logic            wr;
    logic [31:0]     nstart;
    logic [32:0]     nend;
    logic [TagW-1:0] ntag;
  } command_t;

  // Sorted region table plus the queue of outcomes still owed by the block.
  class region_scoreboard;
    logic [31:0]     region_lo  [Depth];
    logic [32:0]     region_hi  [Depth];
    logic [TagW-1:0] region_tag [Depth];
    int unsigned     used;
    outcome_t        owed[$];
    int unsigned     failures;

    function new();
      used     = 0;
      failures = 0;
    endfunction

    function outcome_t lookup(logic [31:0] addr, logic [1:0] slog, logic wr);
      outcome_t    o;
      logic [32:0] span_end;
      o.status = ST_NO_REGION;
      o.tag    = '0;
      o.wr     = wr;
      if (slog > SZ_WORD || (addr & ((32'd1 << slog) - 32'd1)) != 32'd0) begin
        o.status = ST_MISALIGNED;
        return o;
      end
      span_end = {1'b0, addr} + (33'd1 << slog);
      for (int i = 0; i < used; i++) begin
        if (region_lo[i] <= addr && region_hi[i] >= span_end) begin
          o.status = ST_OK;
          o.tag    = region_tag[i];
          return o;
        end
        if (region_lo[i] > addr) break;
      end
      return o;
    endfunction

    function outcome_t insert(logic [31:0] s, logic [32:0] e, logic [TagW-1:0] t);
      outcome_t    o;
      int unsigned pos;
      o.status = ST_OK;
      o.tag    = '0;
      o.wr     = 1'b0;
      pos      = 0;
      while (pos < used && region_lo[pos] <= s) pos++;
      if ((pos > 0 && region_hi[pos-1] > {1'b0, s}) ||
          (pos < used && {1'b0, region_lo[pos]} < e)) begin
        o.status = ST_OVERLAP;
      end else if (used >= Depth) begin
        o.status = ST_FULL;
      end else begin
        for (int i = used; i > pos; i--) begin
          region_lo[i]  = region_lo[i-1];
          region_hi[i]  = region_hi[i-1];
          region_tag[i] = region_tag[i-1];
        end
        region_lo[pos]  = s;
        region_hi[pos]  = e;
        region_tag[pos] = t;
        used++;
      end
      return o;
    endfunction

    function void note_command(command_t c);
      outcome_t o;
      if (c.kind == KIND_REGISTER) o = insert(c.nstart, c.nend, c.ntag);
      else o = lookup(c.addr, c.slog, c.wr);
      owed = {owed, o};
    endfunction

    function void check_result(logic [StatusW-1:0] st, logic [TagW-1:0] tg, logic wr);
      outcome_t o;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: status %0d tag %0d write %0b", st, tg, wr);
        return;
      end
      o = owed.pop_front();
      if (st !== o.status || tg !== o.tag || wr !== o.wr) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: status exp %0d got %0d, tag exp %0d got %0d, write exp %0b got %0b",
                   o.status, st, o.tag, tg, o.wr, wr);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start_i       = 1'b0;
  logic                kind_i        = KIND_ACCESS;
  logic [31:0]         address_i     = '0;
  logic [1:0]          size_log_i    = SZ_BYTE;
  logic                is_write_i    = 1'b0;
  logic [31:0]         new_start_i   = '0;
  logic [32:0]         new_end_i     = '0;
  logic [TagW-1:0]     new_tag_i     = '0;
  logic                busy_o;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [TagW-1:0]     hit_tag_o;
  logic                fault_write_o;

  region_scoreboard sb = new();
  int unsigned      quiet_cycles = 0;
  int unsigned      burst_left   = 0;

  memory_region_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .size_log_i    (size_log_i),
    .is_write_i    (is_write_i),
    .new_start_i   (new_start_i),
    .new_end_i     (new_end_i),
    .new_tag_i     (new_tag_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .hit_tag_o     (hit_tag_o),
    .fault_write_o (fault_write_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitor and watchdog: all values sampled are pre-edge.
  always @(posedge clk_i) begin
    command_t c;
    logic     moved;
    moved = 1'b0;
    if (done_o === 1'b1) begin
      sb.check_result(status_o, hit_tag_o, fault_write_o);
      moved = 1'b1;
    end
    if (rst_ni && start_i && busy_o === 1'b0) begin
      c.kind   = kind_i;
      c.addr   = address_i;
      c.slog   = size_log_i;
      c.wr     = is_write_i;
      c.nstart = new_start_i;
      c.nend   = new_end_i;
      c.ntag   = new_tag_i;
      sb.note_command(c);
      moved = 1'b1;
    end
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic command_t mk_access(logic [31:0] a, logic [1:0] sl, logic wr);
    command_t c;
    c.kind   = KIND_ACCESS;
    c.addr   = a;
    c.slog   = sl;
    c.wr     = wr;
    c.nstart = $urandom;
    c.nend   = {1'($urandom_range(0, 1)), 32'($urandom)};
    c.ntag   = 4'($urandom);
    return c;
  endfunction

  function automatic command_t mk_region(logic [31:0] s, logic [32:0] e, logic [TagW-1:0] t);
    command_t c;
    c.kind   = KIND_REGISTER;
    c.addr   = $urandom;
    c.slog   = 2'($urandom);
    c.wr     = 1'($urandom);
    c.nstart = s;
    c.nend   = (e > AddrTop) ? AddrTop : e;
    c.ntag   = t;
    return c;
  endfunction

  // Drive one beat at the current edge, hold until taken, then maybe idle.
  task automatic issue(command_t c);
    int unsigned gap;
    kind_i      <= c.kind;
    address_i   <= c.addr;
    size_log_i  <= c.slog;
    is_write_i  <= c.wr;
    new_start_i <= c.nstart;
    new_end_i   <= c.nend;
    new_tag_i   <= c.ntag;
    start_i     <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(19, 40) : $urandom_range(0, 18);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_directed();
    // empty table, alignment and undefined width
    issue(mk_access(32'h0000_0000, SZ_BYTE, 1'b0));
    issue(mk_access(32'hFFFF_FFFC, SZ_WORD, 1'b1));
    issue(mk_access(32'h0000_0001, SZ_HALF, 1'b1));
    issue(mk_access(32'h0000_0002, SZ_WORD, 1'b0));
    issue(mk_access(32'h0000_0000, SZ_UNDEF, 1'b1));
    // table build: bottom, top (end one past the address space), empty, same start,
    // inverted, odd end
    issue(mk_region(32'h0000_0000, 33'h0_0000_0100, 4'd1));
    issue(mk_region(32'hFFFF_FF00, AddrTop, 4'd15));
    issue(mk_region(32'h0000_1000, 33'h0_0000_1000, 4'd2));
    issue(mk_region(32'h0000_1000, 33'h0_0000_1100, 4'd3));
    issue(mk_region(32'h9000_0000, 33'h0_0000_0010, 4'd4));
    issue(mk_region(32'h0000_2000, 33'h0_0000_2003, 4'd6));
    // overlaps with the preceding and the following region
    issue(mk_region(32'h0000_0080, 33'h0_0000_0200, 4'd7));
    issue(mk_region(32'h0000_0800, 33'h0_0000_1001, 4'd8));
    // touching on both sides is fine
    issue(mk_region(32'h0000_0100, 33'h0_0000_1000, 4'd5));
    issue(mk_access(32'hFFFF_FFFC, SZ_WORD, 1'b0));
    issue(mk_access(32'h0000_00FC, SZ_WORD, 1'b1));
    issue(mk_access(32'h0000_00FE, SZ_HALF, 1'b0));
    issue(mk_access(32'h0000_0FFC, SZ_WORD, 1'b0));
    issue(mk_access(32'h0000_1000, SZ_BYTE, 1'b1));
    issue(mk_access(32'h9000_0000, SZ_BYTE, 1'b0));
    issue(mk_access(32'h0000_1100, SZ_BYTE, 1'b1));
    issue(mk_access(32'hFFFF_FEFC, SZ_WORD, 1'b0));
    // word runs past an odd region end
    issue(mk_access(32'h0000_2000, SZ_WORD, 1'b1));
    issue(mk_access(32'h0000_2002, SZ_BYTE, 1'b0));
  endtask

  function automatic command_t rand_region();
    logic [31:0] s;
    logic [32:0] e;
    int unsigned i;
    if (sb.used > 0 && ($urandom_range(0, 9) < 3 || sb.used >= Depth) &&
        $urandom_range(0, 1) == 0) begin
      // aimed at an existing region's edges
      i = $urandom_range(0, sb.used - 1);
      s = sb.region_lo[i] + $urandom_range(0, 31) - 32'd16;
      e = {1'b0, s} + $urandom_range(1, 64);
      return mk_region(s, e, 4'($urandom));
    end
    s = $urandom;
    case ($urandom_range(0, 9))
      0:       e = {1'b0, s};
      1:       e = {1'b0, s >> 1};
      2, 3, 4: e = {1'b0, s} + $urandom_range(1, 1 << 20);
      default: e = {1'b0, s} + $urandom_range(1, 256);
    endcase
    return mk_region(s, e, 4'($urandom));
  endfunction

  function automatic command_t rand_access();
    logic [31:0] a;
    logic [32:0] span;
    logic [1:0]  sl;
    int unsigned i;
    sl = ($urandom_range(0, 19) == 0) ? SZ_UNDEF : 2'($urandom_range(0, 2));
    if (sb.used > 0 && $urandom_range(0, 99) < 65) begin
      i = $urandom_range(0, sb.used - 1);
      case ($urandom_range(0, 2))
        0: a = sb.region_lo[i] + $urandom_range(0, 7);
        1: a = sb.region_hi[i][31:0] - $urandom_range(0, 7);
        default: begin
          span = sb.region_hi[i] - {1'b0, sb.region_lo[i]};
          a = sb.region_lo[i];
          if (sb.region_hi[i] > {1'b0, sb.region_lo[i]})
            a = sb.region_lo[i] + 32'({1'b0, $urandom} % span);
        end
      endcase
    end else begin
      a = $urandom;
    end
    if ($urandom_range(0, 3) != 0) a = a & ~((32'd1 << sl) - 32'd1);
    return mk_access(a, sl, 1'($urandom));
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int n = 0; n < RandItems; n++) begin
      if ($urandom_range(0, 99) < 12) issue(rand_region());
      else issue(rand_access());
    end
    start_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 4) @(posedge clk_i);
    if (sb.failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
